### hdl/sstat_pkg.sv
// Shared types, codes and default sizes for the sample set statistics block.
`default_nettype none

package sstat_pkg;

   // Default sizes of the sample store and of one sample.
   parameter int DEFAULT_CAPACITY        = 1024;
   parameter int DEFAULT_SAMPLE_BITS     = 16;
   parameter int DEFAULT_COUNT_BITS      = $clog2(DEFAULT_CAPACITY + 1);
   parameter int DEFAULT_SQUARE_SUM_BITS = 2 * DEFAULT_SAMPLE_BITS + DEFAULT_COUNT_BITS - 1;

   // Request opcodes.
   typedef enum logic {
      OP_PUSH   = 1'b0,
      OP_FINISH = 1'b1
   } opcode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_DROPPED = 2'd2
   } status_type;

   // Commands from the controller to the sorting chain.
   typedef struct packed {
      logic push;
      logic unload;
   } chain_ctrl_type;

endpackage

`default_nettype wire

### hdl/sstat_cell.sv
// One cell of the sorting chain: holds one sample and passes the larger value on.
`default_nettype none

module sstat_cell
  #(parameter int INDEX       = 0,
    parameter int SAMPLE_BITS = sstat_pkg::DEFAULT_SAMPLE_BITS,
    parameter int TAG_BITS    = $clog2(sstat_pkg::DEFAULT_CAPACITY))
   (input  logic                          clock,
    input  logic                          reset,
    input  logic                          unload,
    input  logic                          in_valid,
    input  logic [TAG_BITS-1:0]           in_tag,
    input  logic signed [SAMPLE_BITS-1:0] in_value,
    input  logic signed [SAMPLE_BITS-1:0] right_value,
    output logic                          out_valid,
    output logic [TAG_BITS-1:0]           out_tag,
    output logic signed [SAMPLE_BITS-1:0] out_value,
    output logic signed [SAMPLE_BITS-1:0] stored_value);

   import sstat_pkg::*;

   logic signed [SAMPLE_BITS-1:0] stored_ff, stored_in;
   logic                          out_valid_ff, out_valid_in;
   logic [TAG_BITS-1:0]           out_tag_ff, out_tag_in;
   logic signed [SAMPLE_BITS-1:0] out_value_ff, out_value_in;

   // A token whose tag names this cell finds it empty and settles here.
   // Otherwise the cell keeps the smaller value and hands the larger one on.
   // During unloading the whole row moves one place towards the head.
   always_comb begin
      stored_in    = stored_ff;
      out_valid_in = 1'b0;
      out_tag_in   = in_tag;
      out_value_in = out_value_ff;
      if (unload) begin
         stored_in = right_value;
      end else if (in_valid) begin
         if (in_tag == TAG_BITS'(INDEX)) begin
            stored_in = in_value;
         end else begin
            out_valid_in = 1'b1;
            if (in_value < stored_ff) begin
               stored_in    = in_value;
               out_value_in = stored_ff;
            end else begin
               out_value_in = in_value;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      stored_ff    <= stored_in;
      out_tag_ff   <= out_tag_in;
      out_value_ff <= out_value_in;
   end

   assign out_valid    = out_valid_ff;
   assign out_tag      = out_tag_ff;
   assign out_value    = out_value_ff;
   assign stored_value = stored_ff;

endmodule

`default_nettype wire

### hdl/sstat_sort_chain.sv
// Row of sorting cells that keeps the stored samples in ascending order.
`default_nettype none

module sstat_sort_chain
  #(parameter int CAPACITY    = sstat_pkg::DEFAULT_CAPACITY,
    parameter int SAMPLE_BITS = sstat_pkg::DEFAULT_SAMPLE_BITS,
    parameter int TAG_BITS    = $clog2(sstat_pkg::DEFAULT_CAPACITY))
   (input  logic                          clock,
    input  logic                          reset,
    input  sstat_pkg::chain_ctrl_type     ctrl,
    input  logic [TAG_BITS-1:0]           push_tag,
    input  logic signed [SAMPLE_BITS-1:0] push_value,
    output logic signed [SAMPLE_BITS-1:0] head_value);

   import sstat_pkg::*;

   // Entry stage in front of the first cell.
   logic                          entry_valid_ff, entry_valid_in;
   logic [TAG_BITS-1:0]           entry_tag_ff, entry_tag_in;
   logic signed [SAMPLE_BITS-1:0] entry_value_ff, entry_value_in;

   // Link i feeds cell i; link 0 is the entry stage.
   logic                          link_valid [CAPACITY+1];
   logic [TAG_BITS-1:0]           link_tag   [CAPACITY+1];
   logic signed [SAMPLE_BITS-1:0] link_value [CAPACITY+1];
   logic signed [SAMPLE_BITS-1:0] stored     [CAPACITY];
   logic signed [SAMPLE_BITS-1:0] right      [CAPACITY];

   // A new sample enters with the ordinal of the place it will fill.
   always_comb begin
      entry_valid_in = ctrl.push;
      entry_tag_in   = push_tag;
      entry_value_in = push_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_tag_ff   <= entry_tag_in;
      entry_value_ff <= entry_value_in;
   end

   assign link_valid[0] = entry_valid_ff;
   assign link_tag[0]   = entry_tag_ff;
   assign link_value[0] = entry_value_ff;

   // The cells, each fed by its left neighbour and refilled from its right one.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_last
         assign right[i] = stored[i];
      end else begin : g_inner
         assign right[i] = stored[i+1];
      end

      sstat_cell
        #(.INDEX       (i),
          .SAMPLE_BITS (SAMPLE_BITS),
          .TAG_BITS    (TAG_BITS))
      u_cell
         (.clock        (clock),
          .reset        (reset),
          .unload       (ctrl.unload),
          .in_valid     (link_valid[i]),
          .in_tag       (link_tag[i]),
          .in_value     (link_value[i]),
          .right_value  (right[i]),
          .out_valid    (link_valid[i+1]),
          .out_tag      (link_tag[i+1]),
          .out_value    (link_value[i+1]),
          .stored_value (stored[i]));
   end

   assign head_value = stored[0];

endmodule

`default_nettype wire

### hdl/sstat_divider.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none

module sstat_divider
  #(parameter int DIVIDEND_BITS = sstat_pkg::DEFAULT_SQUARE_SUM_BITS,
    parameter int DIVISOR_BITS  = sstat_pkg::DEFAULT_COUNT_BITS)
   (input  logic                     clock,
    input  logic                     reset,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient);

   import sstat_pkg::*;

   localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic                     active_ff, active_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      fits  = trial >= {1'b0, divisor_ff};
      diff  = trial - {1'b0, divisor_ff};
   end

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      active_in  = active_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
         step_in    = STEP_BITS'(DIVIDEND_BITS);
         active_in  = 1'b1;
      end else if (active_ff) begin
         rem_in  = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### hdl/sstat_isqrt.sv
// Integer square root, one result bit per cycle from two radicand bits.
`default_nettype none

module sstat_isqrt
  #(parameter int ROOT_BITS = sstat_pkg::DEFAULT_SAMPLE_BITS)
   (input  logic                     clock,
    input  logic                     reset,
    input  logic                     start,
    input  logic [2*ROOT_BITS-1:0]   radicand,
    output logic                     done,
    output logic [ROOT_BITS-1:0]     root);

   import sstat_pkg::*;

   localparam int STEP_BITS = $clog2(ROOT_BITS + 1);

   logic [2*ROOT_BITS-1:0] rad_ff, rad_in;
   logic [ROOT_BITS+1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   active_ff, active_in;
   logic                   done_ff, done_in;
   logic [ROOT_BITS+1:0]   shifted;
   logic [ROOT_BITS+1:0]   trial;
   logic                   fits;

   // Bring down the next bit pair and compare with four times the root plus one.
   always_comb begin
      shifted = {rem_ff[ROOT_BITS-1:0], rad_ff[2*ROOT_BITS-1:2*ROOT_BITS-2]};
      trial   = {root_ff, 2'b01};
      fits    = shifted >= trial;
   end

   always_comb begin
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rad_in    = radicand;
         rem_in    = '0;
         root_in   = '0;
         step_in   = STEP_BITS'(ROOT_BITS);
         active_in = 1'b1;
      end else if (active_ff) begin
         rad_in  = {rad_ff[2*ROOT_BITS-3:0], 2'b00};
         rem_in  = fits ? shifted - trial : shifted;
         root_in = {root_ff[ROOT_BITS-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

### hdl/sample_set_statistics.sv
// Top level of the sample set statistics block: controller, accumulators and units.
// A request is taken at a rising edge with start high and busy low. A push request
// (opcode 0) stores one sample; pushes are taken one per cycle and give no result.
// Each sample enters a row of sorting cells and ripples one cell per cycle to its
// place, so the row stays in ascending order. A push to a full set is dropped and
// flagged. A finish request (opcode 1) raises busy, waits for the row to settle
// (n samples kept), shifts the row n/2 places towards its head to expose the
// median, runs two bit-serial divisions (sum and sum of squares by n), then a
// bit-serial square root of the variance. A finish on an empty set answers in
// the next cycle without raising busy. The result is shown for exactly one cycle
// with rsp_valid high; the receiver cannot stall it. Finish clears the set.
// Reset empties the set and the row at once; no clearing pass is needed.
`default_nettype none

module sample_set_statistics
  #(parameter int CAPACITY    = sstat_pkg::DEFAULT_CAPACITY,
    parameter int SAMPLE_BITS = sstat_pkg::DEFAULT_SAMPLE_BITS)
   (input  logic                               clock,
    input  logic                               reset,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_opcode,
    input  logic signed [SAMPLE_BITS-1:0]      req_sample,
    output logic                               rsp_valid,
    output logic [1:0]                         rsp_status,
    output logic [$clog2(CAPACITY+1)-1:0]      rsp_sample_count,
    output logic signed [SAMPLE_BITS-1:0]      rsp_minimum,
    output logic signed [SAMPLE_BITS-1:0]      rsp_maximum,
    output logic signed [SAMPLE_BITS-1:0]      rsp_mean_value,
    output logic signed [SAMPLE_BITS-1:0]      rsp_median_value,
    output logic [2*SAMPLE_BITS-2:0]           rsp_variance_value,
    output logic [SAMPLE_BITS-1:0]             rsp_deviation_value);

   import sstat_pkg::*;

   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
   localparam int TAG_BITS    = $clog2(CAPACITY);
   localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS - 1;
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int VAR_BITS    = 2 * SAMPLE_BITS - 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_UNLOAD,
      ST_DIV_SUM,
      ST_DIV_SQUARES,
      ST_MEAN_SQUARE,
      ST_VARIANCE,
      ST_ROOT
   } state_type;

   // Controller and accumulator registers.
   state_type                     state_ff, state_in;
   logic                          busy_ff, busy_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic [COUNT_BITS-1:0]         step_ff, step_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SQ_BITS-1:0]            sumsq_ff, sumsq_in;
   logic                          dropped_ff, dropped_in;
   logic [PROD_BITS-1:0]          square_ff, square_in;
   logic                          square_valid_ff, square_valid_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [PROD_BITS-1:0]          msq_ff, msq_in;
   logic [PROD_BITS-1:0]          m2_ff, m2_in;
   logic [VAR_BITS-1:0]           var_ff, var_in;

   // Result registers.
   logic                          rsp_valid_ff, rsp_valid_in;
   status_type                    rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0]         rsp_count_ff, rsp_count_in;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff, rsp_min_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic signed [SAMPLE_BITS-1:0] rsp_mean_ff, rsp_mean_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff, rsp_median_in;
   logic [VAR_BITS-1:0]           rsp_var_ff, rsp_var_in;
   logic [SAMPLE_BITS-1:0]        rsp_dev_ff, rsp_dev_in;

   // Combinational helpers.
   logic                          accept;
   logic                          push_accept;
   logic                          finish_accept;
   logic                          has_room;
   logic signed [PROD_BITS-1:0]   sample_product;
   logic signed [PROD_BITS-1:0]   mean_product;
   logic                          sum_neg;
   logic [SUM_BITS-1:0]           sum_mag;
   logic [SUM_BITS-1:0]           quo_low;
   logic [SUM_BITS-1:0]           mean_full;
   logic [VAR_BITS-1:0]           variance_next;
   chain_ctrl_type                chain_ctrl;
   logic signed [SAMPLE_BITS-1:0] head_value;
   logic                          div_start;
   logic [SQ_BITS-1:0]            div_dividend;
   logic                          div_done;
   logic [SQ_BITS-1:0]            div_quotient;
   logic                          root_start;
   logic                          root_done;
   logic [SAMPLE_BITS-1:0]        root_value;

   // Request decode.
   always_comb begin
      accept        = start && !busy_ff;
      push_accept   = accept && (req_opcode == OP_PUSH);
      finish_accept = accept && (req_opcode == OP_FINISH);
      has_room      = count_ff < COUNT_BITS'(CAPACITY);
   end

   // Arithmetic shared by the controller.
   always_comb begin
      sample_product = req_sample * req_sample;
      mean_product   = mean_ff * mean_ff;
      sum_neg        = sum_ff[SUM_BITS-1];
      sum_mag        = sum_neg ? -sum_ff : sum_ff;
      quo_low        = div_quotient[SUM_BITS-1:0];
      mean_full      = sum_neg ? -quo_low : quo_low;
      variance_next  = (msq_ff >= m2_ff) ? VAR_BITS'(msq_ff - m2_ff) : '0;
   end

   // Unit launches: the sum division closes the unload phase, the division of the
   // sum of squares follows straight on, and the root starts with the variance.
   always_comb begin
      chain_ctrl.push   = push_accept && has_room;
      chain_ctrl.unload = (state_ff == ST_UNLOAD) && (step_ff != '0);
      div_start         = ((state_ff == ST_UNLOAD) && (step_ff == '0)) ||
                          ((state_ff == ST_DIV_SUM) && div_done);
      div_dividend      = (state_ff == ST_UNLOAD) ? SQ_BITS'(sum_mag) : sumsq_ff;
      root_start        = state_ff == ST_VARIANCE;
   end

   // Next-state logic of the controller and the running statistics.
   always_comb begin
      state_in        = state_ff;
      busy_in         = busy_ff;
      count_in        = count_ff;
      step_in         = step_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      sum_in          = sum_ff;
      sumsq_in        = sumsq_ff;
      dropped_in      = dropped_ff;
      square_in       = sample_product;
      square_valid_in = 1'b0;
      mean_in         = mean_ff;
      msq_in          = msq_ff;
      m2_in           = m2_ff;
      var_in          = var_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_min_in      = rsp_min_ff;
      rsp_max_in      = rsp_max_ff;
      rsp_mean_in     = rsp_mean_ff;
      rsp_median_in   = rsp_median_ff;
      rsp_var_in      = rsp_var_ff;
      rsp_dev_in      = rsp_dev_ff;

      // The square of a pushed sample is registered and added in the cycle after the push.
      if (square_valid_ff) begin
         sumsq_in = sumsq_ff + SQ_BITS'(square_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (push_accept) begin
               if (has_room) begin
                  if ((count_ff == '0) || (req_sample < min_ff)) begin
                     min_in = req_sample;
                  end
                  if ((count_ff == '0) || (req_sample > max_ff)) begin
                     max_in = req_sample;
                  end
                  sum_in          = sum_ff + SUM_BITS'(req_sample);
                  square_valid_in = 1'b1;
                  count_in        = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end else if (finish_accept) begin
               if (count_ff == '0) begin
                  // An empty set answers at once with every value zero.
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_count_in  = '0;
                  rsp_min_in    = '0;
                  rsp_max_in    = '0;
                  rsp_mean_in   = '0;
                  rsp_median_in = '0;
                  rsp_var_in    = '0;
                  rsp_dev_in    = '0;
                  dropped_in    = 1'b0;
               end else begin
                  busy_in  = 1'b1;
                  step_in  = count_ff;
                  state_in = ST_DRAIN;
               end
            end
         end

         // Let the last samples ripple to their places in the row.
         ST_DRAIN: begin
            if (step_ff == '0) begin
               step_in  = count_ff >> 1;
               state_in = ST_UNLOAD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end

         // Shift the row until the median sits in the head cell.
         ST_UNLOAD: begin
            if (step_ff == '0) begin
               state_in = ST_DIV_SUM;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end

         ST_DIV_SUM: begin
            if (div_done) begin
               mean_in  = mean_full[SAMPLE_BITS-1:0];
               state_in = ST_DIV_SQUARES;
            end
         end

         ST_DIV_SQUARES: begin
            if (div_done) begin
               msq_in   = div_quotient[PROD_BITS-1:0];
               state_in = ST_MEAN_SQUARE;
            end
         end

         ST_MEAN_SQUARE: begin
            m2_in    = mean_product;
            state_in = ST_VARIANCE;
         end

         ST_VARIANCE: begin
            var_in   = variance_next;
            state_in = ST_ROOT;
         end

         // Deliver the result and clear the set.
         ST_ROOT: begin
            if (root_done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = dropped_ff ? STATUS_DROPPED : STATUS_OK;
               rsp_count_in  = count_ff;
               rsp_min_in    = min_ff;
               rsp_max_in    = max_ff;
               rsp_mean_in   = mean_ff;
               rsp_median_in = head_value;
               rsp_var_in    = var_ff;
               rsp_dev_in    = root_value;
               busy_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
      endcase

      // Any finish clears the set and the dropped flag.
      if ((finish_accept && (count_ff == '0)) || ((state_ff == ST_ROOT) && root_done)) begin
         count_in   = '0;
         min_in     = '0;
         max_in     = '0;
         sum_in     = '0;
         sumsq_in   = '0;
         dropped_in = 1'b0;
      end
   end

   // State, accumulators and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         busy_ff         <= 1'b0;
         count_ff        <= '0;
         min_ff          <= '0;
         max_ff          <= '0;
         sum_ff          <= '0;
         sumsq_ff        <= '0;
         dropped_ff      <= 1'b0;
         square_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         busy_ff         <= busy_in;
         count_ff        <= count_in;
         min_ff          <= min_in;
         max_ff          <= max_in;
         sum_ff          <= sum_in;
         sumsq_ff        <= sumsq_in;
         dropped_ff      <= dropped_in;
         square_valid_ff <= square_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      step_ff       <= step_in;
      square_ff     <= square_in;
      mean_ff       <= mean_in;
      msq_ff        <= msq_in;
      m2_ff         <= m2_in;
      var_ff        <= var_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_median_ff <= rsp_median_in;
      rsp_var_ff    <= rsp_var_in;
      rsp_dev_ff    <= rsp_dev_in;
   end

   // Sorting row holding the samples.
   sstat_sort_chain
     #(.CAPACITY    (CAPACITY),
       .SAMPLE_BITS (SAMPLE_BITS),
       .TAG_BITS    (TAG_BITS))
   u_chain
      (.clock      (clock),
       .reset      (reset),
       .ctrl       (chain_ctrl),
       .push_tag   (count_ff[TAG_BITS-1:0]),
       .push_value (req_sample),
       .head_value (head_value));

   // Shared divider for the mean and the mean of squares.
   sstat_divider
     #(.DIVIDEND_BITS (SQ_BITS),
       .DIVISOR_BITS  (COUNT_BITS))
   u_divider
      (.clock    (clock),
       .reset    (reset),
       .start    (div_start),
       .dividend (div_dividend),
       .divisor  (count_ff),
       .done     (div_done),
       .quotient (div_quotient));

   // Square root of the variance.
   sstat_isqrt
     #(.ROOT_BITS (SAMPLE_BITS))
   u_isqrt
      (.clock    (clock),
       .reset    (reset),
       .start    (root_start),
       .radicand ({1'b0, variance_next}),
       .done     (root_done),
       .root     (root_value));

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_sample_count    = rsp_count_ff;
   assign rsp_minimum         = rsp_min_ff;
   assign rsp_maximum         = rsp_max_ff;
   assign rsp_mean_value      = rsp_mean_ff;
   assign rsp_median_value    = rsp_median_ff;
   assign rsp_variance_value  = rsp_var_ff;
   assign rsp_deviation_value = rsp_dev_ff;

   // Busy only drops when the finished result is delivered.
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result");

   // A push request never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == OP_PUSH)) |=> !rsp_valid)
      else $error("result after a push request");

   // An empty-set result reports no samples.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_EMPTY)) |-> (rsp_sample_count == '0))
      else $error("empty-set result with a sample count");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for the sample set statistics block, with its own statistics predictor.

module tb_top;
   import sstat_pkg::*;

   localparam int CAP = DEFAULT_CAPACITY;
   localparam int SB  = DEFAULT_SAMPLE_BITS;
   localparam int CB  = DEFAULT_COUNT_BITS;
   localparam int VB  = 2 * SB - 1;

   typedef struct {
      opcode_type           opcode;
      logic signed [SB-1:0] sample;
   } request_type;

   typedef struct {
      status_type           status;
      logic [CB-1:0]        count;
      logic signed [SB-1:0] minimum;
      logic signed [SB-1:0] maximum;
      logic signed [SB-1:0] mean;
      logic signed [SB-1:0] median;
      logic [VB-1:0]        variance;
      logic [SB-1:0]        deviation;
   } stats_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 start      = 1'b0;
   logic                 req_opcode = 1'b0;
   logic signed [SB-1:0] req_sample = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [CB-1:0]        rsp_sample_count;
   logic signed [SB-1:0] rsp_minimum;
   logic signed [SB-1:0] rsp_maximum;
   logic signed [SB-1:0] rsp_mean_value;
   logic signed [SB-1:0] rsp_median_value;
   logic [VB-1:0]        rsp_variance_value;
   logic [SB-1:0]        rsp_deviation_value;

   // Pending requests, and the statistics still owed by the block.
   request_type request_backlog[$];
   stats_type   stats_due[$];

   int planned_total  = 0;
   int issued_total   = 0;
   int accepted_total = 0;
   int push_total     = 0;
   int finish_total   = 0;
   int empty_total    = 0;
   int dropped_total  = 0;
   int mismatches     = 0;

   // Predictor copy of the sample set.
   logic signed [SB-1:0] set_samples[CAP];
   logic signed [SB-1:0] sort_buf[CAP];
   int                   set_count      = 0;
   longint               set_sum        = 0;
   longint               set_square_sum = 0;
   logic signed [SB-1:0] set_min        = '0;
   logic signed [SB-1:0] set_max        = '0;
   bit                   set_dropped    = 1'b0;

   sample_set_statistics u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_sample_count    (rsp_sample_count),
      .rsp_minimum         (rsp_minimum),
      .rsp_maximum         (rsp_maximum),
      .rsp_mean_value      (rsp_mean_value),
      .rsp_median_value    (rsp_median_value),
      .rsp_variance_value  (rsp_variance_value),
      .rsp_deviation_value (rsp_deviation_value));

   // Clock with a period of 12 units.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Largest integer whose square does not exceed the value, found bit by bit.
   function automatic longint floor_root(longint value);
      longint root;
      longint trial;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= value)
            root = trial;
      end
      return root;
   endfunction

   // Updates the predicted set for one accepted request; a finish queues its statistics.
   task automatic absorb_request(request_type r);
      stats_type            s;
      longint               mean;
      longint               mean_square;
      longint               spread;
      longint               root;
      logic signed [SB-1:0] v;
      int                   j;
      if (r.opcode == OP_PUSH) begin
         push_total++;
         if (set_count >= CAP) begin
            set_dropped = 1'b1;
            dropped_total++;
         end else begin
            if (set_count == 0 || r.sample < set_min)
               set_min = r.sample;
            if (set_count == 0 || r.sample > set_max)
               set_max = r.sample;
            set_samples[set_count] = r.sample;
            set_sum += longint'(r.sample);
            set_square_sum += longint'(r.sample) * longint'(r.sample);
            set_count++;
         end
      end else begin
         finish_total++;
         s.status    = STATUS_OK;
         s.count     = '0;
         s.minimum   = '0;
         s.maximum   = '0;
         s.mean      = '0;
         s.median    = '0;
         s.variance  = '0;
         s.deviation = '0;
         if (set_count == 0) begin
            s.status = STATUS_EMPTY;
            empty_total++;
         end else begin
            // Signed division truncates toward zero, as the mean requires.
            mean        = set_sum / longint'(set_count);
            mean_square = set_square_sum / longint'(set_count);
            spread      = mean_square - mean * mean;
            if (spread < 0)
               spread = 0;
            // Insertion sort of the kept samples to find the median.
            for (int i = 0; i < set_count; i++) begin
               v = set_samples[i];
               j = i;
               while (j > 0 && sort_buf[j-1] > v) begin
                  sort_buf[j] = sort_buf[j-1];
                  j--;
               end
               sort_buf[j] = v;
            end
            s.status    = set_dropped ? STATUS_DROPPED : STATUS_OK;
            s.count     = set_count[CB-1:0];
            s.minimum   = set_min;
            s.maximum   = set_max;
            s.mean      = mean[SB-1:0];
            s.median    = sort_buf[set_count / 2];
            s.variance  = spread[VB-1:0];
            root        = floor_root(longint'(s.variance));
            s.deviation = root[SB-1:0];
         end
         stats_due.push_back(s);
         set_count      = 0;
         set_sum        = 0;
         set_square_sum = 0;
         set_min        = '0;
         set_max        = '0;
         set_dropped    = 1'b0;
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   // Sample values: full range, small, extremes and mid range.
   function automatic logic signed [SB-1:0] pick_sample();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40)
         return SB'($urandom);
      else if (roll < 60)
         return SB'($urandom_range(32) - 16);
      else if (roll < 75) begin
         case ($urandom_range(4))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'sh0001;
         endcase
      end
      return SB'($urandom_range(4095) - 2048);
   endfunction

   task automatic add_request(opcode_type op, logic signed [SB-1:0] value);
      request_type r;
      r.opcode = op;
      r.sample = value;
      request_backlog.push_back(r);
      planned_total++;
   endtask

   // Driver: presents requests at the falling edge and holds each until it is taken.
   always @(negedge clock) begin
      request_type nxt;
      bit          quiet;
      quiet = (issued_total >= 1500 && issued_total < 2300);
      if (reset) begin
         start <= 1'b0;
      end else if (start && accepted_total < issued_total) begin
         // The current request has not been taken yet, so it stays on the ports.
      end else if (request_backlog.size() == 0 || (!quiet && $urandom_range(99) < 9)) begin
         start      <= 1'b0;
         req_opcode <= 1'($urandom);
         req_sample <= SB'($urandom);
      end else begin
         nxt        = request_backlog.pop_front();
         start      <= 1'b1;
         req_opcode <= nxt.opcode;
         req_sample <= nxt.sample;
         issued_total++;
      end
   end

   // Monitor: checks each result against the oldest expectation, then records taken requests.
   always @(posedge clock) begin
      stats_type   want;
      request_type taken;
      if (!reset) begin
         if (rsp_valid !== 1'b0) begin
            if (stats_due.size() == 0) begin
               mismatches++;
               $error("result with no finish request outstanding");
            end else begin
               want = stats_due.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("sample_count", 32'(want.count), 32'(rsp_sample_count));
               check_field("minimum", 32'(want.minimum), 32'(rsp_minimum));
               check_field("maximum", 32'(want.maximum), 32'(rsp_maximum));
               check_field("mean_value", 32'(want.mean), 32'(rsp_mean_value));
               check_field("median_value", 32'(want.median), 32'(rsp_median_value));
               check_field("variance_value", 32'(want.variance), 32'(rsp_variance_value));
               check_field("deviation_value", 32'(want.deviation),
                           32'(rsp_deviation_value));
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            taken.opcode = opcode_type'(req_opcode);
            taken.sample = req_sample;
            absorb_request(taken);
            accepted_total++;
         end
      end
   end

   // Stimulus, reset and the end of the run.
   initial begin
      int size;
      int roll;

      // Directed sets: empty finish, extremes, truncation of negative means, repeated empties.
      add_request(OP_FINISH, 16'sh1234);
      add_request(OP_PUSH, 16'sh7fff);
      add_request(OP_PUSH, 16'sh8000);
      add_request(OP_FINISH, 16'sh0000);
      add_request(OP_PUSH, 16'sh0000);
      add_request(OP_FINISH, 16'shffff);
      add_request(OP_PUSH, -16'sd3);
      add_request(OP_PUSH, -16'sd4);
      add_request(OP_PUSH, -16'sd8);
      add_request(OP_FINISH, 16'sh7fff);
      add_request(OP_PUSH, 16'sd5);
      add_request(OP_PUSH, -16'sd7);
      add_request(OP_FINISH, 16'sh8000);
      add_request(OP_PUSH, 16'sh0100);
      add_request(OP_PUSH, 16'sh00ff);
      add_request(OP_PUSH, 16'shff00);
      add_request(OP_PUSH, 16'sh8001);
      add_request(OP_FINISH, 16'sh5555);
      add_request(OP_FINISH, 16'shaaaa);
      add_request(OP_FINISH, 16'sh0001);
      // A set of the most negative value gives the most negative mean.
      for (int i = 0; i < 3; i++)
         add_request(OP_PUSH, 16'sh8000);
      add_request(OP_FINISH, 16'sh0000);

      // Random sets, mostly small, with occasional empty and longer ones.
      while (planned_total < 960) begin
         roll = $urandom_range(99);
         if (roll < 6)
            size = 0;
         else if (roll < 80)
            size = $urandom_range(12, 1);
         else if (roll < 96)
            size = $urandom_range(64, 13);
         else
            size = $urandom_range(300, 65);
         for (int i = 0; i < size; i++)
            add_request(OP_PUSH, pick_sample());
         add_request(OP_FINISH, pick_sample());
      end

      // A full set of alternating extremes gives the largest variance; the surplus
      // pushes beyond capacity are dropped and flagged, and an empty finish follows.
      for (int i = 0; i < CAP; i++)
         add_request(OP_PUSH, (i % 2 == 0) ? 16'sh7fff : 16'sh8000);
      for (int i = 0; i < 6; i++)
         add_request(OP_PUSH, pick_sample());
      add_request(OP_FINISH, pick_sample());
      add_request(OP_FINISH, pick_sample());
      add_request(OP_PUSH, 16'sh0042);
      add_request(OP_PUSH, -16'sd9);
      add_request(OP_FINISH, pick_sample());

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || accepted_total != issued_total ||
             stats_due.size() != 0)
         @(posedge clock);
      // Let any stray result show itself before closing.
      repeat (64) @(posedge clock);

      $display("Run covered %0d pushes (%0d dropped at capacity) and %0d finishes,",
               push_total, dropped_total, finish_total);
      $display("%0d of them on an empty set; %0d mismatches found.", empty_total, mismatches);
      if (mismatches == 0)
         $display("PASS sample_set_statistics");
      else
         $display("FAIL sample_set_statistics");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(12 * 3000000);
      $display("FAIL sample_set_statistics");
      $finish;
   end

endmodule
